/* rtl/core/glos_pkg.sv */
// shared types and constants for the grid line-of-sight checker
`default_nettype none
package glos_pkg;

  localparam int GRID_COLUMNS_DEF = 256;
  localparam int GRID_ROWS_DEF    = 256;
  localparam int COORD_W          = 8;
  localparam int COST_W           = 8;
  localparam int ERR_W            = 11;
  localparam int LIMIT_W          = 13;
  localparam logic [COST_W-1:0] THRESHOLD_RESET = 8'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               at_end;
  } walk_stat_t;

endpackage
`default_nettype wire

/* rtl/core/grid_line_of_sight_check_top.sv */
// top level of the grid line-of-sight checker
`default_nettype none
// holds a grid of 8-bit cell costs and answers line queries. a word with op
// = write stores cell_cost at (start_x, start_y) and gives no result; a write
// outside the grid is dropped. a word with op = query walks the bresenham line
// from start to end, both ends included, and returns one result word:
// blocked = 1 as soon as a visited cell is outside the grid or its cost is at
// or above occupied_threshold, else blocked = 0. a zero error term steps the
// minor axis only when the major direction is positive, so the walk is
// symmetric. a query is accepted, then the walk visits cells up to the first
// blocked cell (at most max(|dx|, |dy|) + 1, so up to 256) at one cell per
// cycle, set by the single read port of the cost memory, whose registered data
// is compared in the cycle after the address goes out. no new word is taken
// during a walk. the result sits in an output register; a finished walk waits
// there only if the previous result has not been taken. the grid is not
// cleared at reset: load every cell a query can reach before querying. the
// threshold register is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while the block is idle, which the block does not enforce.
module grid_line_of_sight_check_top #(
  parameter int GRID_COLUMNS = glos_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = glos_pkg::GRID_ROWS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [glos_pkg::COST_W-1:0]  cfg_wdata_i,
  // input words
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic [glos_pkg::COORD_W-1:0] start_x_i,
  input  wire logic [glos_pkg::COORD_W-1:0] start_y_i,
  input  wire logic [glos_pkg::COORD_W-1:0] end_x_i,
  input  wire logic [glos_pkg::COORD_W-1:0] end_y_i,
  input  wire logic [glos_pkg::COST_W-1:0]  cell_cost_i,
  // result words
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              blocked_o
);
  import glos_pkg::*;

  // only coordinates below 256 can occur, so address bits cap at the coord width
  localparam int ColW  = (GRID_COLUMNS >= (1 << COORD_W)) ? COORD_W : $clog2(GRID_COLUMNS);
  localparam int RowW  = (GRID_ROWS >= (1 << COORD_W)) ? COORD_W : $clog2(GRID_ROWS);
  localparam int AddrW = ColW + RowW;
  localparam logic [LIMIT_W-1:0] ColLimit = LIMIT_W'(GRID_COLUMNS);
  localparam logic [LIMIT_W-1:0] RowLimit = LIMIT_W'(GRID_ROWS);

  state_e             state_q, state_d;
  logic [COST_W-1:0]  thr_q;
  logic               out_valid_q, out_valid_d;
  logic               blocked_q, blocked_d;
  // one-deep pipeline entry: cell whose memory read is in flight
  logic               pend_valid_q, pend_valid_d;
  logic               pend_oob_q, pend_oob_d;
  logic               pend_last_q, pend_last_d;
  logic               issue_done_q, issue_done_d;

  walk_ctrl_t         walk_ctrl;
  walk_stat_t         walk_stat;

  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  logic [COST_W-1:0]  mem_rdata;

  logic               in_accept, wr_in_grid, cur_in_grid;
  logic               hit_now, done_now, out_free;

  assign in_accept = in_valid_i && in_ready_o;

  // grid bounds for the write address and for the cell being issued
  assign wr_in_grid  = ({{(LIMIT_W-COORD_W){1'b0}}, start_x_i} < ColLimit)
                    && ({{(LIMIT_W-COORD_W){1'b0}}, start_y_i} < RowLimit);
  assign cur_in_grid = ({{(LIMIT_W-COORD_W){1'b0}}, walk_stat.x} < ColLimit)
                    && ({{(LIMIT_W-COORD_W){1'b0}}, walk_stat.y} < RowLimit);

  assign mem_waddr = {start_y_i[RowW-1:0], start_x_i[ColW-1:0]};
  assign mem_raddr = {walk_stat.y[RowW-1:0], walk_stat.x[ColW-1:0]};

  // result of the cell whose data just came back
  assign hit_now  = pend_valid_q && (pend_oob_q || (mem_rdata >= thr_q));
  assign done_now = pend_valid_q && (hit_now || pend_last_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      issue_done_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      issue_done_q <= issue_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blocked_q   <= blocked_d;
    pend_oob_q  <= pend_oob_d;
    pend_last_q <= pend_last_d;
  end

  // sequencer: idle takes words, walk issues one cell and checks one per cycle
  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    blocked_d      = blocked_q;
    pend_valid_d   = pend_valid_q;
    pend_oob_d     = pend_oob_q;
    pend_last_d    = pend_last_q;
    issue_done_d   = issue_done_q;
    walk_ctrl.load = 1'b0;
    walk_ctrl.step = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // ready is high in idle, so a valid word is taken here
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_WRITE: begin
              mem_we = wr_in_grid;
            end
            OP_QUERY: begin
              walk_ctrl.load = 1'b1;
              pend_valid_d   = 1'b0;
              issue_done_d   = 1'b0;
              state_d        = ST_WALK;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (done_now) begin
          // hold everything until the output register can take the result
          if (out_free) begin
            out_valid_d  = 1'b1;
            blocked_d    = hit_now;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if (!issue_done_q) begin
          mem_re         = 1'b1;
          pend_valid_d   = 1'b1;
          pend_oob_d     = !cur_in_grid;
          pend_last_d    = walk_stat.at_end;
          walk_ctrl.step = !walk_stat.at_end;
          issue_done_d   = walk_stat.at_end;
        end else begin
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign blocked_o   = blocked_q;

  glos_walker u_walker (
    .clk_i     (clk_i),
    .ctrl_i    (walk_ctrl),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .stat_o    (walk_stat)
  );

  glos_grid_mem #(
    .ADDR_W (AddrW)
  ) u_grid_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cell_cost_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // a cell read is only in flight during a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_WALK))
    else $error("cell read pending outside a walk");

  // a query starts its walk with an empty pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (op_i == OP_QUERY)) |=>
      ((state_q == ST_WALK) && !(pend_valid_q || issue_done_q)))
    else $error("walk did not start clean");

  // once the last cell is issued, its check stays pending until the walk ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && issue_done_q) |-> pend_valid_q)
    else $error("last cell lost before its check");

  // a result is only produced while the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !$rose(state_q == ST_IDLE) || $stable(blocked_q))
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

/* rtl/core/glos_grid_mem.sv */
// cell cost memory, one write port and one registered read port
`default_nettype none
module glos_grid_mem #(
  parameter int ADDR_W = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [ADDR_W-1:0]          waddr_i,
  input  wire logic [glos_pkg::COST_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [ADDR_W-1:0]          raddr_i,
  output logic      [glos_pkg::COST_W-1:0] rdata_o
);
  import glos_pkg::*;

  localparam int Depth = 2 ** ADDR_W;

  logic [COST_W-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/glos_walker.sv */
// bresenham stepper: position registers and one shared error adder
`default_nettype none
module glos_walker (
  input  wire logic                         clk_i,
  input  wire glos_pkg::walk_ctrl_t         ctrl_i,
  input  wire logic [glos_pkg::COORD_W-1:0] start_x_i,
  input  wire logic [glos_pkg::COORD_W-1:0] start_y_i,
  input  wire logic [glos_pkg::COORD_W-1:0] end_x_i,
  input  wire logic [glos_pkg::COORD_W-1:0] end_y_i,
  output glos_pkg::walk_stat_t              stat_o
);
  import glos_pkg::*;

  logic                      x_major_q, x_major_d;
  logic                      maj_pos_q, maj_pos_d;
  logic                      min_pos_q, min_pos_d;
  logic                      min_move_q, min_move_d;
  logic [COORD_W-1:0]        maj_q, maj_d;
  logic [COORD_W-1:0]        min_q, min_d;
  logic [COORD_W-1:0]        maj_end_q, maj_end_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [ERR_W-1:0]   inc_q, inc_d;
  logic signed [ERR_W-1:0]   dec_q, dec_d;

  logic [COORD_W-1:0]        adx, ady, maj_abs, min_abs;
  logic                      x_major;
  logic                      take;
  logic signed [ERR_W-1:0]   add_a, add_b, add_sum;

  // load-time deltas
  always_comb begin
    adx     = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
    ady     = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
    x_major = (adx >= ady);
    maj_abs = x_major ? adx : ady;
    min_abs = x_major ? ady : adx;
  end

  // tie on zero error steps the minor axis only for a positive major direction
  assign take = (err_q > 0) || ((err_q == '0) && maj_pos_q);

  // shared adder: initial error on load, error update on each step
  always_comb begin
    if (ctrl_i.load) begin
      add_a = ERR_W'(signed'({2'b00, min_abs, 1'b0}));
      add_b = -ERR_W'(signed'({3'b000, maj_abs}));
    end else begin
      add_a = err_q;
      add_b = take ? dec_q : inc_q;
    end
    add_sum = add_a + add_b;
  end

  always_comb begin
    x_major_d  = x_major_q;
    maj_pos_d  = maj_pos_q;
    min_pos_d  = min_pos_q;
    min_move_d = min_move_q;
    maj_d      = maj_q;
    min_d      = min_q;
    maj_end_d  = maj_end_q;
    err_d      = err_q;
    inc_d      = inc_q;
    dec_d      = dec_q;
    if (ctrl_i.load) begin
      x_major_d  = x_major;
      maj_pos_d  = x_major ? (end_x_i > start_x_i) : (end_y_i > start_y_i);
      min_pos_d  = x_major ? (end_y_i > start_y_i) : (end_x_i > start_x_i);
      min_move_d = (min_abs != '0);
      maj_d      = x_major ? start_x_i : start_y_i;
      min_d      = x_major ? start_y_i : start_x_i;
      maj_end_d  = x_major ? end_x_i : end_y_i;
      err_d      = add_sum;
      inc_d      = ERR_W'(signed'({2'b00, min_abs, 1'b0}));
      dec_d      = ERR_W'(signed'({2'b00, min_abs, 1'b0}))
                 - ERR_W'(signed'({2'b00, maj_abs, 1'b0}));
    end else if (ctrl_i.step) begin
      err_d = add_sum;
      maj_d = maj_pos_q ? maj_q + 1'b1 : maj_q - 1'b1;
      if (take && min_move_q) begin
        min_d = min_pos_q ? min_q + 1'b1 : min_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_major_q  <= x_major_d;
    maj_pos_q  <= maj_pos_d;
    min_pos_q  <= min_pos_d;
    min_move_q <= min_move_d;
    maj_q      <= maj_d;
    min_q      <= min_d;
    maj_end_q  <= maj_end_d;
    err_q      <= err_d;
    inc_q      <= inc_d;
    dec_q      <= dec_d;
  end

  always_comb begin
    stat_o.x      = x_major_q ? maj_q : min_q;
    stat_o.y      = x_major_q ? min_q : maj_q;
    stat_o.at_end = (maj_q == maj_end_q);
  end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for grid_line_of_sight_check_top: directed table, then random phases
`default_nettype none
module tb_top;
  import glos_pkg::*;

  // kind of a row in the directed table
  typedef enum logic {
    ROW_WORD,
    ROW_THRESHOLD
  } row_kind_e;

  // one directed row; for a threshold row the value rides in cost
  typedef struct packed {
    row_kind_e          kind;
    op_e                op;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COST_W-1:0]  cost;
    logic               typed;
    logic               blk;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 28;
  localparam int NUM_PHASES   = 6;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_QUERIES = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COST_W-1:0]  cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               op_i;
  logic [COORD_W-1:0] start_x_i;
  logic [COORD_W-1:0] start_y_i;
  logic [COORD_W-1:0] end_x_i;
  logic [COORD_W-1:0] end_y_i;
  logic [COST_W-1:0]  cell_cost_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               blocked_o;

  grid_line_of_sight_check_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .cell_cost_i (cell_cost_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .blocked_o   (blocked_o)
  );

  always #2 clk_i = ~clk_i;

  // mirror of the cost grid; a cell counts as loaded once a write word for it was taken
  logic [COST_W-1:0] grid_cost   [0:GRID_COLUMNS_DEF*GRID_ROWS_DEF-1];
  bit                grid_loaded [0:GRID_COLUMNS_DEF*GRID_ROWS_DEF-1];
  logic [COST_W-1:0] occ_threshold;

  // blocked flags still owed by the block, oldest first
  logic blocked_exp_q [$];

  int errors     = 0;
  int words_sent = 0;
  bit tx_idle_en;
  bit rx_idle_en;
  int hold_req   = 0;

  // current random window: small lines inside it keep walks short
  int win_x;
  int win_y;
  int win_span;

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    // lone cell below the reset threshold, then the far corner at full cost
    '{ROW_WORD, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
    '{ROW_WORD, OP_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 1'b1},
    // cost exactly at the threshold blocks, one below does not
    '{ROW_WORD, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd2,   1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1},
    '{ROW_WORD, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
    // full-length lines along rows 0 and 255 and both diagonals, unused cells load as zero
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 1'b1},
    '{ROW_WORD, OP_QUERY, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1},
    '{ROW_WORD, OP_WRITE, 8'd128, 8'd0,   8'd0,   8'd0,   8'd200, 1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 1'b1},
    '{ROW_WORD, OP_QUERY, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1},
    // zero error term on the first step, x major then y major, both directions;
    // the cell beside the true path is occupied
    '{ROW_WORD, OP_WRITE, 8'd11,  8'd10,  8'd0,   8'd0,   8'd255, 1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd10,  8'd10,  8'd12,  8'd11,  8'd0,   1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd12,  8'd11,  8'd10,  8'd10,  8'd0,   1'b0, 1'b0},
    '{ROW_WORD, OP_WRITE, 8'd20,  8'd21,  8'd0,   8'd0,   8'd255, 1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd20,  8'd20,  8'd21,  8'd22,  8'd0,   1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd21,  8'd22,  8'd20,  8'd20,  8'd0,   1'b0, 1'b0},
    // zero threshold blocks everything
    '{ROW_THRESHOLD, OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0,   1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd10,  8'd10,  8'd12,  8'd11,  8'd0,   1'b1, 1'b1},
    // top threshold: only a full-cost cell blocks
    '{ROW_THRESHOLD, OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0,  8'd255, 1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   1'b1, 1'b1},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 1'b0},
    '{ROW_THRESHOLD, OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0,  8'd1,   1'b0, 1'b0},
    '{ROW_WORD, OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1}
  };

  // cells of the line from start to end, both ends included, as row * columns + column
  function automatic void trace_line(input int x0, input int y0, input int x1, input int y1,
                                     ref int cells[$]);
    int x;
    int y;
    int sx;
    int sy;
    int dx;
    int dy;
    int err;
    x  = x0;
    y  = y0;
    sx = (x1 > x0) ? 1 : (x1 < x0) ? -1 : 0;
    sy = (y1 > y0) ? 1 : (y1 < y0) ? -1 : 0;
    dx = 2 * ((x1 > x0) ? x1 - x0 : x0 - x1);
    dy = 2 * ((y1 > y0) ? y1 - y0 : y0 - y1);
    cells.delete();
    cells = {cells, y * GRID_COLUMNS_DEF + x};
    if (dx >= dy) begin
      err = dy - dx / 2;
      while (x != x1) begin
        // on a tie the minor axis moves only while walking in the positive direction
        if (err > 0 || (err == 0 && sx > 0)) begin
          err -= dx;
          y   += sy;
        end
        err += dy;
        x   += sx;
        cells = {cells, y * GRID_COLUMNS_DEF + x};
      end
    end else begin
      err = dx - dy / 2;
      while (y != y1) begin
        if (err > 0 || (err == 0 && sy > 0)) begin
          err -= dy;
          x   += sx;
        end
        err += dx;
        y   += sy;
        cells = {cells, y * GRID_COLUMNS_DEF + x};
      end
    end
  endfunction

  // coordinates are 8 bits on a 256 x 256 grid, so no walk leaves the grid
  function automatic logic line_is_blocked(input int x0, input int y0, input int x1,
                                           input int y1);
    int cells[$];
    trace_line(x0, y0, x1, y1, cells);
    foreach (cells[i])
      if (grid_cost[cells[i]] >= occ_threshold) return 1'b1;
    return 1'b0;
  endfunction

  // mostly free cells and some occupied ones; a zero threshold makes every cell occupied
  function automatic logic [COST_W-1:0] pick_cost();
    if (occ_threshold == '0 || $urandom_range(0, 6) == 0)
      return COST_W'($urandom_range(int'(occ_threshold), 255));
    return COST_W'($urandom_range(0, int'(occ_threshold) - 1));
  endfunction

  function automatic int win_coord(input int base);
    int v;
    v = base + $urandom_range(0, win_span);
    return (v > 255) ? 255 : v;
  endfunction

  // offer one word and hold it until taken; valid stays high afterwards
  task automatic send_word(input op_e op, input logic [COORD_W-1:0] sx,
                           input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] ex,
                           input logic [COORD_W-1:0] ey, input logic [COST_W-1:0] cost,
                           input bit typed = 1'b0, input bit typed_blk = 1'b0);
    logic exp_blk;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    start_x_i   <= sx;
    start_y_i   <= sy;
    end_x_i     <= ex;
    end_y_i     <= ey;
    cell_cost_i <= cost;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    // words are taken in order, so the mirror is updated at acceptance
    if (op == OP_WRITE) begin
      grid_cost[int'(sy) * GRID_COLUMNS_DEF + int'(sx)]   = cost;
      grid_loaded[int'(sy) * GRID_COLUMNS_DEF + int'(sx)] = 1'b1;
    end else begin
      exp_blk = typed ? typed_blk
                      : line_is_blocked(int'(sx), int'(sy), int'(ex), int'(ey));
      blocked_exp_q = {blocked_exp_q, exp_blk};
    end
  endtask

  // write every cell of the line that was never written, so no query reads an unset cell
  task automatic load_line(input int x0, input int y0, input int x1, input int y1,
                           input bit zero_fill);
    int cells[$];
    trace_line(x0, y0, x1, y1, cells);
    foreach (cells[i])
      if (!grid_loaded[cells[i]])
        send_word(OP_WRITE, COORD_W'(cells[i] % GRID_COLUMNS_DEF),
                  COORD_W'(cells[i] / GRID_COLUMNS_DEF), COORD_W'($urandom),
                  COORD_W'($urandom), zero_fill ? 8'd0 : pick_cost());
  endtask

  task automatic query_line(input int x0, input int y0, input int x1, input int y1,
                            input bit zero_fill = 1'b0, input bit typed = 1'b0,
                            input bit typed_blk = 1'b0);
    load_line(x0, y0, x1, y1, zero_fill);
    send_word(OP_QUERY, COORD_W'(x0), COORD_W'(y0), COORD_W'(x1), COORD_W'(y1),
              COST_W'($urandom), typed, typed_blk);
  endtask

  // stop offering, wait for every owed result, then let a trailing write settle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (blocked_exp_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [COST_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    occ_threshold = value;
  endtask

  // mostly short queries inside the window, some rewrites, stray writes and long lines
  task automatic random_word();
    if ($urandom_range(0, 19) == 0) begin
      win_x    = $urandom_range(0, 255);
      win_y    = $urandom_range(0, 255);
      win_span = $urandom_range(1, 15);
    end
    case ($urandom_range(0, 29))
      0, 1, 2, 3: send_word(OP_WRITE, COORD_W'(win_coord(win_x)), COORD_W'(win_coord(win_y)),
                            COORD_W'($urandom), COORD_W'($urandom), pick_cost());
      4:          send_word(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom),
                            COORD_W'($urandom), COORD_W'($urandom), pick_cost());
      5:          query_line($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255));
      default:    query_line(win_coord(win_x), win_coord(win_y), win_coord(win_x),
                             win_coord(win_y));
    endcase
  endtask

  // result side: checks each taken word and stalls in random bursts or one long hold
  initial begin : result_side
    int   idle_left;
    int   hold_seen;
    logic want;
    idle_left = 0;
    hold_seen = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (blocked_exp_q.size() == 0) begin
          $error("blocked: expected no result word, actual %0b", blocked_o);
          errors++;
        end else begin
          want = blocked_exp_q.pop_front();
          if (blocked_o !== want) begin
            $error("blocked: expected %0b, actual %0b", want, blocked_o);
            errors++;
          end
        end
      end
      // a long hold lets the output register and the walk behind it fill up
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left > 0) begin
        idle_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // word side: reset, directed rows, then random phases each under its own threshold
  initial begin : word_side
    logic [COST_W-1:0] phase_thr [NUM_PHASES];
    int                phase_len [NUM_PHASES];
    int                hx0 [HOLD_QUERIES];
    int                hy0 [HOLD_QUERIES];
    int                hx1 [HOLD_QUERIES];
    int                hy1 [HOLD_QUERIES];
    int                stop_at;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    op_i        <= OP_WRITE;
    start_x_i   <= '0;
    start_y_i   <= '0;
    end_x_i     <= '0;
    end_y_i     <= '0;
    cell_cost_i <= '0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    occ_threshold = THRESHOLD_RESET;
    win_x         = 0;
    win_y         = 0;
    win_span      = 7;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; lines load their unset cells as zero so typed results hold
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_THRESHOLD)
        set_threshold(dir_rows[i].cost);
      else if (dir_rows[i].op == OP_WRITE)
        send_word(OP_WRITE, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey,
                  dir_rows[i].cost);
      else
        query_line(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey, 1'b1,
                   dir_rows[i].typed, dir_rows[i].blk);
    end

    // the directed lines already load about a thousand cells
    phase_thr = '{8'd255, 8'd0, 8'($urandom), 8'd1, 8'd128, 8'($urandom)};
    phase_len = '{80, 30, 90, 80, 80, 90};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_threshold(phase_thr[p]);
      // last phase runs back to back on both sides
      if (p == NUM_PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      stop_at = words_sent + phase_len[p];
      if (p == 2) begin
        // load a batch of short lines, then fire their queries into a stalled receiver
        for (int k = 0; k < HOLD_QUERIES; k++) begin
          hx0[k] = win_coord(win_x);
          hy0[k] = win_coord(win_y);
          hx1[k] = win_coord(win_x);
          hy1[k] = win_coord(win_y);
          load_line(hx0[k], hy0[k], hx1[k], hy1[k], 1'b0);
        end
        hold_req++;
        tx_idle_en = 1'b0;
        for (int k = 0; k < HOLD_QUERIES; k++)
          send_word(OP_QUERY, COORD_W'(hx0[k]), COORD_W'(hy0[k]), COORD_W'(hx1[k]),
                    COORD_W'(hy1[k]), COST_W'($urandom));
        tx_idle_en = 1'b1;
      end
      while (words_sent < stop_at) random_word();
    end

    settle();
    // a stray extra word would show up well within one full walk
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("grid_line_of_sight_check_top test passed");
    end else begin
      $display("grid_line_of_sight_check_top test failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #16000000;
    $display("grid_line_of_sight_check_top test failed");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/glos_pkg.sv
rtl/core/glos_grid_mem.sv
rtl/core/glos_walker.sv
rtl/core/grid_line_of_sight_check_top.sv
tb/tb_top.sv
